>>> src/wavhp_pkg.sv
// Package with the shared types and constants of the WAV header parser.
`timescale 1ns / 1ps

package wavhp_pkg;

  // Chunk and header ids as they read little-endian off the byte stream.
  localparam logic [31:0] IdRiff = 32'h4646_4952;
  localparam logic [31:0] IdWave = 32'h4556_4157;
  localparam logic [31:0] IdFmt  = 32'h2074_6d66;
  localparam logic [31:0] IdData = 32'h6174_6164;

  // Data lengths at or above this value mean play to the end.
  localparam logic [31:0] LenLimit = 32'h7fff_fffe;

  // Smallest fmt body that carries every field we decode.
  localparam logic [31:0] FmtMinLen = 32'd16;

  // Parser phase.
  typedef enum logic [2:0] {
    PhRiff,
    PhHdr1,
    PhSkip1,
    PhFmt,
    PhHdr2,
    PhSkip2,
    PhDone
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    StOk,
    StNotRiff,
    StShortFmt,
    StNotPcm,
    StNoChan,
    StBadBits,
    StBadCont
  } status_e;

  // Sample formats.
  typedef enum logic [2:0] {
    FmtU8,
    FmtS16,
    FmtS24In3,
    FmtS24In4,
    FmtS32
  } sfmt_e;

  // One input beat.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       first;
  } in_t;

  // One result beat.
  typedef struct packed {
    status_e     status;
    sfmt_e       sample_format;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [30:0] data_length;
    logic        length_unlimited;
  } out_t;

endpackage

>>> src/wavhp_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface wavhp_in_if;
  logic          valid;
  logic          ready;
  wavhp_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wavhp_out_if;
  logic           valid;
  logic           ready;
  wavhp_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/wav_header_parser.sv
// Top level of the RIFF/WAVE header parser.
`timescale 1ns / 1ps

// The block takes a WAV file on in_if, one byte per beat, and sets first on
// the beat that carries byte 0 of a file. It checks the RIFF/WAVE header,
// skips chunks until the fmt chunk, decodes the fmt body, then skips chunks
// until the data chunk header and sends one beat on out_if with the status,
// sample format, channel count, sample rate and data length. An error ends
// the file early with one beat that carries only the status. After a result
// further bytes are dropped until the next first beat; a truncated file
// gives no result.
// Each byte is consumed in the cycle it is accepted, so the block takes one
// byte per cycle while in_if.ready is high. A result is registered into the
// output register, or into the skid while the output register is stalled.
// These two result slots sit behind the parser; in_if.ready drops only while
// both hold a beat that the receiver has not taken, so a stalled receiver
// backs up the input after the second pending result.
// Reset clears the parser to the start of a file and empties both slots.
module wav_header_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  wavhp_in_if.sink           in_if,
  wavhp_out_if.source        out_if
);

  typedef struct packed {
    wavhp_pkg::status_e st;
    wavhp_pkg::sfmt_e   sf;
  } dec_t;

  // Decode the fmt fields into a status and a sample format.
  function automatic dec_t decode(input logic [15:0] fc, input logic [15:0] ch,
                                  input logic [15:0] ba, input logic [15:0] bits);
    logic [17:0] ch3;
    logic [17:0] ch4;
    logic [17:0] ch5;
    logic [17:0] bax;
    dec_t        r;
    ch3  = {2'b00, ch} + {1'b0, ch, 1'b0};
    ch4  = {ch, 2'b00};
    ch5  = {ch, 2'b00} + {2'b00, ch};
    bax  = {2'b00, ba};
    r.st = wavhp_pkg::StOk;
    r.sf = wavhp_pkg::FmtU8;
    if (fc != 16'd1) begin
      r.st = wavhp_pkg::StNotPcm;
    end else if (ch == 16'd0) begin
      r.st = wavhp_pkg::StNoChan;
    end else begin
      case (bits)
        16'd8: begin
          r.sf = wavhp_pkg::FmtU8;
        end
        16'd16: begin
          r.sf = wavhp_pkg::FmtS16;
        end
        16'd24: begin
          if (bax >= ch3 && bax < ch4) begin
            r.sf = wavhp_pkg::FmtS24In3;
          end else if (bax >= ch4 && bax < ch5) begin
            r.sf = wavhp_pkg::FmtS24In4;
          end else begin
            r.st = wavhp_pkg::StBadCont;
          end
        end
        16'd32: begin
          r.sf = wavhp_pkg::FmtS32;
        end
        default: begin
          r.st = wavhp_pkg::StBadBits;
        end
      endcase
    end
    if (r.st != wavhp_pkg::StOk) begin
      r.sf = wavhp_pkg::FmtU8;
    end
    return r;
  endfunction

  // Parser state.
  wavhp_pkg::phase_e phase_q, phase_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              match_q, match_d;
  logic              is_fmt_q, is_fmt_d;
  logic              is_data_q, is_data_d;
  logic [23:0]       len_q, len_d;
  logic [32:0]       rem_q, rem_d;
  logic [15:0]       fc_q, fc_d;
  logic [15:0]       ch_q, ch_d;
  logic [31:0]       rate_q, rate_d;
  logic [15:0]       ba_q, ba_d;
  logic [15:0]       bits_q, bits_d;
  wavhp_pkg::sfmt_e  sf_q, sf_d;

  // Result slots.
  logic              ov_q, sv_q;
  wavhp_pkg::out_t   od_q, sd_q;

  logic              in_fire;
  logic [7:0]        b;
  wavhp_pkg::phase_e ph;
  logic [4:0]        k;
  logic [31:0]       len_full;
  logic [32:0]       padded;
  logic              hdr_last;
  logic              riff_last;
  logic              riff_ok;
  logic              rem_last;
  logic              fmt_now;
  logic              data_now;
  dec_t              dec;
  logic              produce;
  wavhp_pkg::out_t   res;

  assign in_fire = in_if.valid && in_if.ready;
  assign b       = in_if.data.byte_in;

  // A first beat restarts the parse at byte 0.
  assign ph = in_if.data.first ? wavhp_pkg::PhRiff : phase_q;
  assign k  = in_if.data.first ? 5'd0 : cnt_q;

  // Byte-wise compare against RIFF and WAVE; bytes 4 to 7 are the size.
  always_comb begin
    match_d = match_q;
    if (k == 5'd0) begin
      match_d = (b == wavhp_pkg::IdRiff[7:0]);
    end else if (k < 5'd4) begin
      match_d = match_q && (b == wavhp_pkg::IdRiff[{k[1:0], 3'b000} +: 8]);
    end else if (k >= 5'd8) begin
      match_d = match_q && (b == wavhp_pkg::IdWave[{k[1:0], 3'b000} +: 8]);
    end
  end

  assign riff_last = (k == 5'd11);
  assign riff_ok   = match_d;

  // Chunk header: id flags over bytes 0 to 3, length over bytes 4 to 7.
  always_comb begin
    is_fmt_d  = is_fmt_q;
    is_data_d = is_data_q;
    len_d     = len_q;
    if (k == 5'd0) begin
      is_fmt_d  = (b == wavhp_pkg::IdFmt[7:0]);
      is_data_d = (b == wavhp_pkg::IdData[7:0]);
    end else if (k < 5'd4) begin
      is_fmt_d  = is_fmt_q && (b == wavhp_pkg::IdFmt[{k[1:0], 3'b000} +: 8]);
      is_data_d = is_data_q && (b == wavhp_pkg::IdData[{k[1:0], 3'b000} +: 8]);
    end else if (k < 5'd7) begin
      len_d[{k[1:0], 3'b000} +: 8] = b;
    end
  end

  assign hdr_last = (k == 5'd7);
  assign len_full = {b, len_q};
  assign padded   = {1'b0, len_full} + {32'd0, len_full[0]};
  assign fmt_now  = (ph == wavhp_pkg::PhHdr1) && is_fmt_q;
  assign data_now = (ph == wavhp_pkg::PhHdr2) && is_data_q;
  assign rem_last = (rem_q == 33'd1);

  // Fmt body fields, one byte at a time over the first sixteen bytes.
  always_comb begin
    fc_d   = fc_q;
    ch_d   = ch_q;
    rate_d = rate_q;
    ba_d   = ba_q;
    bits_d = bits_q;
    if (k < 5'd16) begin
      case (k[3:0]) inside
        4'd0:        fc_d[7:0]                        = b;
        4'd1:        fc_d[15:8]                       = b;
        4'd2:        ch_d[7:0]                        = b;
        4'd3:        ch_d[15:8]                       = b;
        [4'd4:4'd7]: rate_d[{k[1:0], 3'b000} +: 8]    = b;
        4'd12:       ba_d[7:0]                        = b;
        4'd13:       ba_d[15:8]                       = b;
        4'd14:       bits_d[7:0]                      = b;
        4'd15:       bits_d[15:8]                     = b;
        default:     ;
      endcase
    end
  end

  assign dec = decode(fc_d, ch_d, ba_d, bits_d);

  // Next phase.
  always_comb begin
    phase_d = ph;
    case (ph)
      wavhp_pkg::PhRiff: begin
        if (riff_last) begin
          phase_d = riff_ok ? wavhp_pkg::PhHdr1 : wavhp_pkg::PhDone;
        end
      end
      wavhp_pkg::PhHdr1, wavhp_pkg::PhHdr2: begin
        if (hdr_last) begin
          if (fmt_now) begin
            phase_d = (len_full < wavhp_pkg::FmtMinLen) ? wavhp_pkg::PhDone
                                                          : wavhp_pkg::PhFmt;
          end else if (data_now) begin
            phase_d = wavhp_pkg::PhDone;
          end else if (len_full != 32'd0) begin
            phase_d = (ph == wavhp_pkg::PhHdr1) ? wavhp_pkg::PhSkip1
                                                 : wavhp_pkg::PhSkip2;
          end
        end
      end
      wavhp_pkg::PhFmt: begin
        if (rem_last) begin
          phase_d = (dec.st != wavhp_pkg::StOk) ? wavhp_pkg::PhDone
                                                 : wavhp_pkg::PhHdr2;
        end
      end
      wavhp_pkg::PhSkip1: begin
        if (rem_q <= 33'd1) begin
          phase_d = wavhp_pkg::PhHdr1;
        end
      end
      wavhp_pkg::PhSkip2: begin
        if (rem_q <= 33'd1) begin
          phase_d = wavhp_pkg::PhHdr2;
        end
      end
      default: begin
        phase_d = wavhp_pkg::PhDone;
      end
    endcase
  end

  // Counters, stored format and the result of this beat.
  always_comb begin
    cnt_d   = k;
    rem_d   = rem_q;
    sf_d    = sf_q;
    produce = 1'b0;
    res     = '0;
    case (ph)
      wavhp_pkg::PhRiff: begin
        cnt_d = riff_last ? 5'd0 : k + 5'd1;
        if (riff_last && !riff_ok) begin
          produce    = 1'b1;
          res.status = wavhp_pkg::StNotRiff;
        end
      end
      wavhp_pkg::PhHdr1, wavhp_pkg::PhHdr2: begin
        cnt_d = hdr_last ? 5'd0 : k + 5'd1;
        if (hdr_last) begin
          rem_d = padded;
          if (fmt_now && len_full < wavhp_pkg::FmtMinLen) begin
            produce    = 1'b1;
            res.status = wavhp_pkg::StShortFmt;
          end else if (data_now) begin
            produce         = 1'b1;
            res.status      = wavhp_pkg::StOk;
            res.sample_format = sf_q;
            res.channels    = ch_q;
            res.sample_rate = rate_q;
            if (len_full < wavhp_pkg::LenLimit) begin
              res.data_length = len_full[30:0];
            end else begin
              res.length_unlimited = 1'b1;
            end
          end
        end
      end
      wavhp_pkg::PhFmt: begin
        cnt_d = (k < 5'd16) ? k + 5'd1 : k;
        rem_d = rem_q - 33'd1;
        if (rem_last) begin
          cnt_d = 5'd0;
          sf_d  = dec.sf;
          if (dec.st != wavhp_pkg::StOk) begin
            produce    = 1'b1;
            res.status = dec.st;
          end
        end
      end
      wavhp_pkg::PhSkip1, wavhp_pkg::PhSkip2: begin
        cnt_d = 5'd0;
        if (rem_q != 33'd0) begin
          rem_d = rem_q - 33'd1;
        end
      end
      default: begin
        cnt_d = 5'd0;
      end
    endcase
  end

  // Control state of the parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavhp_pkg::PhRiff;
      cnt_q   <= 5'd0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers of the parser.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      match_q   <= match_d;
      is_fmt_q  <= is_fmt_d;
      is_data_q <= is_data_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
      sf_q      <= sf_d;
      if (ph == wavhp_pkg::PhFmt) begin
        fc_q   <= fc_d;
        ch_q   <= ch_d;
        rate_q <= rate_d;
        ba_q   <= ba_d;
        bits_q <= bits_d;
      end
    end
  end

  // Result slots: output register in front, skid register behind it.
  logic out_free;
  logic new_res;

  assign out_free = !ov_q || out_if.ready;
  assign new_res  = in_fire && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (out_free) begin
      ov_q <= sv_q || new_res;
      sv_q <= sv_q && new_res;
    end else if (new_res) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      od_q <= sv_q ? sd_q : res;
      if (sv_q && new_res) begin
        sd_q <= res;
      end
    end else if (new_res) begin
      sd_q <= res;
    end
  end

  assign in_if.ready  = !sv_q;
  assign out_if.valid = ov_q;
  assign out_if.data  = od_q;

endmodule

>>> src/wavhp_chk.sv
// Port-level checker for the WAV header parser and its bind statement.
`timescale 1ns / 1ps

module wavhp_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input wavhp_pkg::out_t out_data_i
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // A new result only ever follows an accepted input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an input beat");

  // An error result carries only its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != wavhp_pkg::StOk |->
      out_data_i.channels == 16'd0 && out_data_i.sample_rate == 32'd0 &&
      out_data_i.data_length == 31'd0 && !out_data_i.length_unlimited &&
      out_data_i.sample_format == wavhp_pkg::FmtU8)
    else $error("error result with nonzero fields");

  // An unbounded length reports no byte count, and an unbounded result has channels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.length_unlimited |->
      out_data_i.data_length == 31'd0 && out_data_i.channels != 16'd0)
    else $error("unbounded result is inconsistent");

endmodule

bind wav_header_parser wavhp_chk u_wavhp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
